/* rtl/pwrcd_pkg.sv */
// Shared constants, types and helper functions of the pulse width remote code decoder.
`timescale 1ns / 1ps

package pwrcd_pkg;

	localparam int GUARD_FACTOR = 36;
	localparam int END_FACTOR   = 4;
	localparam int CODE_WIDTH   = 32;

	localparam int DUR_W  = 24;
	localparam int CFG_W  = 16;
	localparam int MINB_W = 7;
	localparam int CNT_W  = 8;
	localparam int OUT_W  = 32;
	localparam int IDX_W  = 2;
	localparam int SH_W   = $clog2(OUT_W + 1);

	localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

	localparam logic [1:0] PH_GUARD = 2'd0;
	localparam logic [1:0] PH_START = 2'd1;
	localparam logic [1:0] PH_LOW   = 2'd2;
	localparam logic [1:0] PH_HIGH  = 2'd3;

	localparam logic [IDX_W-1:0] REG_SHORT_TIME = 2'd0;
	localparam logic [IDX_W-1:0] REG_LONG_TIME  = 2'd1;
	localparam logic [IDX_W-1:0] REG_TOLERANCE  = 2'd2;
	localparam logic [IDX_W-1:0] REG_MIN_BITS   = 2'd3;

	localparam logic [CFG_W-1:0]  SHORT_TIME_RST = 16'd700;
	localparam logic [CFG_W-1:0]  LONG_TIME_RST  = 16'd1400;
	localparam logic [CFG_W-1:0]  TOLERANCE_RST  = 16'd200;
	localparam logic [MINB_W-1:0] MIN_BITS_RST   = 7'd12;

	typedef struct packed {
		logic guard_ok;
		logic start_ok;
		logic end_hit;
		logic bit0;
		logic bit1;
	} pulse_class_t;

	function automatic logic within_tol(logic [DUR_W-1:0] a, logic [DUR_W-1:0] b,
			logic [DUR_W-1:0] lim);
		logic [DUR_W-1:0] diff;
		diff = (a > b) ? (a - b) : (b - a);
		return diff < lim;
	endfunction

	function automatic logic [OUT_W-1:0] rev_word(logic [OUT_W-1:0] v);
		logic [OUT_W-1:0] r;
		for (int i = 0; i < OUT_W; i++) begin
			r[i] = v[OUT_W-1-i];
		end
		return r;
	endfunction

endpackage

/* rtl/pwrcd_classify.sv */
// Duration checks of one pulse against the configured timing windows.
`timescale 1ns / 1ps

module pwrcd_classify (
	input  logic [pwrcd_pkg::DUR_W-1:0] duration,
	input  logic [pwrcd_pkg::DUR_W-1:0] saved_low,
	input  logic [pwrcd_pkg::CFG_W-1:0] short_time,
	input  logic [pwrcd_pkg::CFG_W-1:0] long_time,
	input  logic [pwrcd_pkg::CFG_W-1:0] tolerance,
	output pwrcd_pkg::pulse_class_t     cls
);
	import pwrcd_pkg::*;

	logic [DUR_W-1:0] short_ext;
	logic [DUR_W-1:0] long_ext;
	logic [DUR_W-1:0] tol_ext;
	logic [DUR_W-1:0] guard_nom;
	logic [DUR_W-1:0] guard_tol;
	logic [DUR_W-1:0] end_lim;

	assign short_ext = DUR_W'(short_time);
	assign long_ext  = DUR_W'(long_time);
	assign tol_ext   = DUR_W'(tolerance);
	assign guard_nom = short_ext * DUR_W'(GUARD_FACTOR);
	assign guard_tol = tol_ext * DUR_W'(GUARD_FACTOR);
	assign end_lim   = short_ext * DUR_W'(END_FACTOR);

	always_comb begin
		cls.guard_ok = within_tol(duration, guard_nom, guard_tol);
		cls.start_ok = within_tol(duration, short_ext, tol_ext);
		cls.end_hit  = duration >= end_lim;
		cls.bit0     = within_tol(saved_low, short_ext, tol_ext)
			&& within_tol(duration, long_ext, tol_ext);
		cls.bit1     = within_tol(saved_low, long_ext, tol_ext)
			&& within_tol(duration, short_ext, tol_ext);
	end

endmodule

/* rtl/pulse_width_remote_code_decoder.sv */
// Top level of the pulse width remote code decoder: pulse register, frame state and result register.
`timescale 1ns / 1ps
// A pulse is held in the pulse register, then its result is registered in the result register.
// Throughput: one pulse per cycle while out_ready does not stall the result register;
// the frame state is updated in the same cycle it is read.
// Reset: asynchronous, active low; clears the frame state and held code, restores register defaults.

module pulse_width_remote_code_decoder (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_write,
	input  logic [pwrcd_pkg::IDX_W-1:0]   cfg_index,
	input  logic [pwrcd_pkg::CFG_W-1:0]   cfg_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          level,
	input  logic [pwrcd_pkg::DUR_W-1:0]   duration,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          code_ready,
	output logic [pwrcd_pkg::OUT_W-1:0]   code,
	output logic [pwrcd_pkg::CNT_W-1:0]   bit_count,
	output logic [pwrcd_pkg::OUT_W-1:0]   reversed_code
);
	import pwrcd_pkg::*;

	logic [CFG_W-1:0]      short_time_q;
	logic [CFG_W-1:0]      long_time_q;
	logic [CFG_W-1:0]      tolerance_q;
	logic [MINB_W-1:0]     min_bits_q;

	logic                  valid_s1;
	logic                  level_s1;
	logic [DUR_W-1:0]      duration_s1;

	logic [1:0]            phase_q;
	logic [CODE_WIDTH-1:0] shift_bits_q;
	logic [CNT_W-1:0]      bits_seen_q;
	logic [DUR_W-1:0]      saved_low_q;
	logic [OUT_W-1:0]      held_code_q;
	logic [CNT_W-1:0]      held_count_q;
	logic [OUT_W-1:0]      held_rev_q;
	logic                  out_valid_q;
	logic                  code_ready_q;

	logic                  adv;
	pulse_class_t          cls;

	logic [1:0]            phase_d;
	logic [CODE_WIDTH-1:0] shift_bits_d;
	logic [CNT_W-1:0]      bits_seen_d;
	logic                  save_low;
	logic                  frame_done;
	logic [OUT_W-1:0]      frame_code;
	logic [SH_W-1:0]       rev_shift;

	assign adv      = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || adv;

	pwrcd_classify u_classify (
		.duration   (duration_s1),
		.saved_low  (saved_low_q),
		.short_time (short_time_q),
		.long_time  (long_time_q),
		.tolerance  (tolerance_q),
		.cls        (cls)
	);

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			short_time_q <= SHORT_TIME_RST;
			long_time_q  <= LONG_TIME_RST;
			tolerance_q  <= TOLERANCE_RST;
			min_bits_q   <= MIN_BITS_RST;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_SHORT_TIME: short_time_q <= cfg_data;
				REG_LONG_TIME:  long_time_q  <= cfg_data;
				REG_TOLERANCE:  tolerance_q  <= cfg_data;
				REG_MIN_BITS:   min_bits_q   <= cfg_data[MINB_W-1:0];
				default: ;
			endcase
		end
	end

	// Pulse register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			level_s1    <= level;
			duration_s1 <= duration;
		end
	end

	// Frame state update
	always_comb begin
		phase_d      = phase_q;
		shift_bits_d = shift_bits_q;
		bits_seen_d  = bits_seen_q;
		save_low     = 1'b0;
		frame_done   = 1'b0;
		unique case (phase_q)
			PH_GUARD: begin
				if (!level_s1 && cls.guard_ok) begin
					phase_d = PH_START;
				end
			end
			PH_START: begin
				if (level_s1) begin
					if (cls.start_ok) begin
						phase_d      = PH_LOW;
						shift_bits_d = '0;
						bits_seen_d  = '0;
					end else begin
						phase_d = PH_GUARD;
					end
				end
			end
			PH_LOW: begin
				priority if (level_s1) begin
					phase_d = PH_GUARD;
				end else if (cls.end_hit) begin
					phase_d    = PH_START;
					frame_done = bits_seen_q >= CNT_W'(min_bits_q);
				end else begin
					save_low = 1'b1;
					phase_d  = PH_HIGH;
				end
			end
			PH_HIGH: begin
				if (level_s1 && (cls.bit0 || cls.bit1)) begin
					shift_bits_d = {shift_bits_q[CODE_WIDTH-2:0], !cls.bit0};
					bits_seen_d  = (bits_seen_q == CNT_MAX) ? bits_seen_q
						: bits_seen_q + CNT_W'(1);
					phase_d      = PH_LOW;
				end else begin
					phase_d = PH_GUARD;
				end
			end
			default: phase_d = PH_GUARD;
		endcase
	end

	assign frame_code = OUT_W'(shift_bits_q);
	assign rev_shift  = (bits_seen_q >= CNT_W'(OUT_W)) ? '0
		: SH_W'(OUT_W) - SH_W'(bits_seen_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_GUARD;
			shift_bits_q <= '0;
			bits_seen_q  <= '0;
			saved_low_q  <= '0;
			held_code_q  <= '0;
			held_count_q <= '0;
			held_rev_q   <= '0;
			code_ready_q <= 1'b0;
		end else if (adv) begin
			phase_q      <= phase_d;
			shift_bits_q <= shift_bits_d;
			bits_seen_q  <= bits_seen_d;
			code_ready_q <= frame_done;
			if (save_low) begin
				saved_low_q <= duration_s1;
			end
			if (frame_done) begin
				held_code_q  <= frame_code;
				held_count_q <= bits_seen_q;
				held_rev_q   <= rev_word(frame_code) >> rev_shift;
			end
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid     = out_valid_q;
	assign code_ready    = code_ready_q;
	assign code          = held_code_q;
	assign bit_count     = held_count_q;
	assign reversed_code = held_rev_q;

`ifndef ASSERT_OFF
	a_report_min_bits: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && code_ready_q |-> held_count_q >= CNT_W'(min_bits_q))
		else $error("reported frame shorter than min_bits");

	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(phase_q) && $stable(held_code_q) && $stable(bits_seen_q))
		else $error("frame state changed without a pulse");

	a_high_in_low: assert property (@(posedge clk) disable iff (!arst_n)
		adv && phase_q == PH_LOW && level_s1 |=> phase_q == PH_GUARD)
		else $error("high pulse in low phase did not restart search");

	a_free_slot: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid_q |-> in_ready)
		else $error("input stalled with empty result register");
`endif

endmodule
